// ----- hw/rtl/tcw_pkg.sv -----
// shared types and constants for the text console writer
// no dependencies; imported by tcw_cell_ram, tcw_sequencer and the top level
package tcw_pkg;

    localparam int CELL_W = 16;
    localparam int POS_W  = 11;

    // request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_MARK  = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // character codes with special handling
    localparam logic [7:0] CODE_BS    = 8'd8;
    localparam logic [7:0] CODE_TAB   = 8'd9;
    localparam logic [7:0] CODE_NL    = 8'd10;
    localparam logic [7:0] CODE_SPACE = 8'd32;

    localparam logic [7:0] RESET_ATTR = 8'h0F;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tcw_mem_ctl_t;

    typedef struct packed {
        logic [POS_W-1:0] cursor_pos;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
        logic             did_scroll;
    } tcw_result_t;

endpackage

// ----- hw/rtl/tcw_cell_ram.sv -----
// screen cell store: one write port, one read port with registered read data
// depends on tcw_pkg
module tcw_cell_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic              aclk,
    input  tcw_mem_ctl_t      mem_ctl,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CELL_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [CELL_W-1:0] rd_data
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while no read is issued
        if (mem_ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/tcw_sequencer.sv -----
// request sequencer: cursor state and the sweep counter that drives fill and scroll passes
// depends on tcw_pkg; drives the cell memory port of tcw_cell_ram
module tcw_sequencer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [1:0]        req_type,
    input  logic [7:0]        char_code,
    input  logic [4:0]        read_row,
    input  logic [6:0]        read_col,
    input  logic [7:0]        text_attribute,
    output logic              res_valid,
    input  logic              res_ready,
    output tcw_result_t       res,
    output tcw_mem_ctl_t      mem_ctl,
    output logic [AW-1:0]     wr_addr,
    output logic [CELL_W-1:0] wr_data,
    output logic [AW-1:0]     rd_addr,
    input  logic [CELL_W-1:0] rd_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int PW    = (AW > POS_W) ? AW : POS_W;

    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] BOTTOM    = AW'(CELLS - COLUMNS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FILL   = 5'b00010,
        S_SCROLL = 5'b00100,
        S_BS_WR  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic [7:0]    fill_attr_reg, fill_attr_next;
    logic          init_reg, init_next;
    logic          scrolled_reg, scrolled_next;
    logic          hit_reg, hit_next;

    logic          line_end;
    logic [AW-1:0] cur_addr;
    logic [PW-1:0] pos_full;
    logic [7:0]    put_char;

    function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c);
        return AW'(int'(r) * COLUMNS + int'(c));
    endfunction

    assign cur_addr   = cell_addr(row_reg, col_reg);
    assign pos_full   = PW'(int'(row_reg) * COLUMNS + int'(col_reg));
    assign put_char   = (char_code == CODE_TAB) ? CODE_SPACE : char_code;
    assign item_ready = (state_reg == S_IDLE);

    always_comb begin
        res.cursor_pos = pos_full[POS_W-1:0];
        res.cell_char  = hit_reg ? rd_data[7:0] : 8'h00;
        res.cell_attr  = hit_reg ? rd_data[15:8] : 8'h00;
        res.did_scroll = scrolled_reg;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        limit_next     = limit_reg;
        fill_attr_next = fill_attr_reg;
        init_next      = init_reg;
        scrolled_next  = scrolled_reg;
        hit_next       = hit_reg;
        line_end       = 1'b0;
        mem_ctl        = '0;
        wr_addr        = cnt_reg;
        wr_data        = {fill_attr_reg, 8'h00};
        rd_addr        = cnt_reg;
        res_valid      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    scrolled_next = 1'b0;
                    hit_next      = 1'b0;
                    state_next    = S_DONE;
                    unique case (req_type)
                        REQ_PUT: begin
                            if (char_code == CODE_NL) begin
                                line_end = 1'b1;
                            end else if (char_code == CODE_BS) begin
                                if (col_reg > limit_reg) begin
                                    col_next       = col_reg - CW'(1);
                                    mem_ctl.rd_en  = 1'b1;
                                    rd_addr        = cur_addr - AW'(1);
                                    cnt_next       = cur_addr - AW'(1);
                                    state_next     = S_BS_WR;
                                end
                            end else begin
                                mem_ctl.wr_en = 1'b1;
                                wr_addr       = cur_addr;
                                wr_data       = {text_attribute, put_char};
                                if (col_reg == LAST_COL) begin
                                    line_end = 1'b1;
                                end else begin
                                    col_next = col_reg + CW'(1);
                                end
                            end
                        end
                        REQ_CLEAR: begin
                            col_next       = '0;
                            row_next       = '0;
                            limit_next     = '0;
                            cnt_next       = '0;
                            fill_attr_next = text_attribute;
                            state_next     = S_FILL;
                        end
                        REQ_MARK: begin
                            limit_next = col_reg;
                        end
                        REQ_READ: begin
                            if (int'(read_row) < ROWS && int'(read_col) < COLUMNS) begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = cell_addr(RW'(read_row), CW'(read_col));
                                hit_next      = 1'b1;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                    // newline or wrap past the last column
                    if (line_end) begin
                        col_next   = '0;
                        limit_next = '0;
                        if (row_reg == LAST_ROW) begin
                            scrolled_next = 1'b1;
                            cnt_next      = '0;
                            state_next    = S_SCROLL;
                        end else begin
                            row_next = row_reg + RW'(1);
                        end
                    end
                end
            end
            S_FILL: begin
                mem_ctl.wr_en = 1'b1;
                if (cnt_reg == LAST_CELL) begin
                    init_next  = 1'b0;
                    state_next = init_reg ? S_IDLE : S_DONE;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_SCROLL: begin
                // read the cell one row below, write it in the following cycle
                if (cnt_reg != BOTTOM) begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = AW'(int'(cnt_reg) + COLUMNS);
                end
                if (cnt_reg != '0) begin
                    mem_ctl.wr_en = 1'b1;
                    wr_addr       = cnt_reg - AW'(1);
                    wr_data       = rd_data;
                end
                if (cnt_reg == BOTTOM) begin
                    fill_attr_next = text_attribute;
                    state_next     = S_FILL;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_BS_WR: begin
                mem_ctl.wr_en = 1'b1;
                wr_data       = {rd_data[15:8], 8'h00};
                state_next    = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_FILL;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            limit_reg     <= '0;
            fill_attr_reg <= RESET_ATTR;
            init_reg      <= 1'b1;
            scrolled_reg  <= 1'b0;
            hit_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            limit_reg     <= limit_next;
            fill_attr_reg <= fill_attr_next;
            init_reg      <= init_next;
            scrolled_reg  <= scrolled_next;
            hit_reg       <= hit_next;
        end
    end

endmodule

// ----- hw/rtl/text_console_writer_core.sv -----
// Text console of ROWS x COLUMNS character cells (default 25 x 80), each cell a character
// byte and an attribute byte held in a single-port-per-direction block memory. After reset
// the block sweeps the memory once to blank it, with s_ready low; cfg writes are taken at
// any time. One request is handled at a time and s_ready is low while it runs. Put,
// newline, tab, mark limit and read cell pass from acceptance through the done state
// to the output register; backspace first reads the cell left of the cursor and then
// writes it back blank with its attribute kept. Clear screen and a put or newline that
// scrolls sweep the cell memory, which moves or blanks one cell per cycle. The output
// register lets the next request be accepted while a result waits on m_ready.
// depends on tcw_pkg, tcw_cell_ram, tcw_sequencer
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_req_type,
    input  logic [7:0]       s_char_code,
    input  logic [4:0]       s_read_row,
    input  logic [6:0]       s_read_col,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [POS_W-1:0] m_cursor_pos,
    output logic [7:0]       m_cell_char,
    output logic [7:0]       m_cell_attr,
    output logic             m_did_scroll
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [7:0]        text_attribute_reg;
    logic              m_valid_reg;
    tcw_result_t       m_res_reg;

    logic              res_valid;
    logic              res_ready;
    tcw_result_t       res;
    tcw_mem_ctl_t      mem_ctl;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [CELL_W-1:0] wr_data;
    logic [CELL_W-1:0] rd_data;

    assign cfg_ready = 1'b1;
    assign res_ready = !m_valid_reg || m_ready;

    tcw_sequencer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_valid     (s_valid),
        .item_ready     (s_ready),
        .req_type       (s_req_type),
        .char_code      (s_char_code),
        .read_row       (s_read_row),
        .read_col       (s_read_col),
        .text_attribute (text_attribute_reg),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .mem_ctl        (mem_ctl),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data)
    );

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attribute_reg <= RESET_ATTR;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                text_attribute_reg <= cfg_data;
            end
            if (res_valid && res_ready) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output payload, loaded only when the slot is free
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_pos = m_res_reg.cursor_pos;
    assign m_cell_char  = m_res_reg.cell_char;
    assign m_cell_attr  = m_res_reg.cell_attr;
    assign m_did_scroll = m_res_reg.did_scroll;

`ifndef SYNTHESIS
    // every accepted request leaves s_ready low in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted back to back");

    // reported position stays on the screen
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (CELLS > 2048) || (int'(m_cursor_pos) < CELLS))
        else $error("cursor position beyond the screen");

    // a scroll always leaves the cursor at column 0 of the last row
    a_scroll_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_did_scroll |-> m_cursor_pos == POS_W'((ROWS - 1) * COLUMNS))
        else $error("scroll left the cursor off the start of the last row");
`endif

endmodule
